/* hdl/bsc_pkg.sv */
// shared types, constants and helpers for the barometric compensation block
package bsc_pkg;

    // calibration register indexes
    localparam logic [2:0] REG_AC1   = 3'd0;
    localparam logic [2:0] REG_AC2   = 3'd1;
    localparam logic [2:0] REG_AC3   = 3'd2;
    localparam logic [2:0] REG_AC4   = 3'd3;
    localparam logic [2:0] REG_AC5   = 3'd4;
    localparam logic [2:0] REG_AC6   = 3'd5;
    localparam logic [2:0] REG_B1_B2 = 3'd6;
    localparam logic [2:0] REG_MC_MD = 3'd7;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DIV = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    localparam int DIV_STAGES  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // pa / 100 by reciprocal, exact over the 18-bit pressure range
    localparam logic [18:0] HPA_RECIP = 19'd335545;
    localparam int          HPA_SHIFT = 25;

    localparam logic [31:0] K_B5_ROUND = 32'd8;
    localparam logic [31:0] K_B6_OFF   = 32'd4000;
    localparam logic [31:0] K_TWO      = 32'd2;
    localparam logic [31:0] K_AC4_OFF  = 32'd32768;
    localparam logic [31:0] K_B7_MUL   = 32'd50000;
    localparam logic [31:0] K_P_MUL1   = 32'd3038;
    localparam logic [31:0] K_P_MUL2   = 32'hFFFF_E343; // -7357
    localparam logic [31:0] K_P_OFF    = 32'd3791;

    localparam logic signed [31:0] T_MAX  = 32'sd4095;
    localparam logic signed [31:0] T_MIN  = -32'sd4096;
    localparam logic signed [31:0] P_MAX  = 32'sd262143;
    localparam logic signed [31:0] T_WARM = 32'sd250;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
    } t_cal;

    // item handed from the front end to the back end
    typedef struct packed {
        logic [15:0] up;
        logic [31:0] x1;
        logic [31:0] d;
        logic        zero_div;
    } t_item;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // signed divide by 2^k, truncating toward zero
    function automatic logic [31:0] sdiv_p2(input logic [31:0] a, input int k);
        logic [31:0] bias;
        bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        return $unsigned($signed(a + bias) >>> k);
    endfunction

endpackage

/* hdl/barometric_sensor_compensation_unit.sv */
// top level of the barometric sensor temperature and pressure compensation block
// accepts one raw temperature / raw pressure pair per cycle while o_ready is high and returns
// one result per transfer, in order; the path runs through the front end, the queue and the
// back end, whose pipeline is dominated by the two 32-stage pipelined dividers,
// one for the temperature quotient and one for the pressure quotient. the back end moves
// as one when its output register is empty or being taken, and a 4-entry queue lets the
// front end keep taking transfers while the back end stalls. calibration is to be written through
// the plain write port only while no transfer is in flight; the block does not enforce this.
module barometric_sensor_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // calibration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // sample input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_raw_temperature,
    input  logic [15:0] i_raw_pressure,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [12:0] o_temperature_tenths,
    output logic [17:0] o_pressure_pa,
    output logic [11:0] o_pressure_hpa,
    output logic        o_warm_alarm,
    output logic [1:0]  o_status
);
    import bsc_pkg::*;

    t_cal  r_cal;
    logic  w_push, w_full, w_pop, w_empty;
    t_item w_front_item, w_queue_item;

    // calibration registers, all cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_AC1:   r_cal.ac1   <= i_cfg_data[15:0];
                REG_AC2:   r_cal.ac2   <= i_cfg_data[15:0];
                REG_AC3:   r_cal.ac3   <= i_cfg_data[15:0];
                REG_AC4:   r_cal.ac4   <= i_cfg_data[15:0];
                REG_AC5:   r_cal.ac5   <= i_cfg_data[15:0];
                REG_AC6:   r_cal.ac6   <= i_cfg_data[15:0];
                REG_B1_B2: r_cal.b1_b2 <= i_cfg_data;
                REG_MC_MD: r_cal.mc_md <= i_cfg_data;
                default:   r_cal <= r_cal;
            endcase
        end
    end

    // front end: first temperature term and zero divisor check
    bsc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cal             (r_cal),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .o_push            (w_push),
        .o_item            (w_front_item),
        .i_full            (w_full)
    );

    // decoupling queue
    bsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_queue_item)
    );

    // back end: dividers, pressure polynomial, clamping
    bsc_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cal                (r_cal),
        .i_empty              (w_empty),
        .i_item               (w_queue_item),
        .o_pop                (w_pop),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_temperature_tenths (o_temperature_tenths),
        .o_pressure_pa        (o_pressure_pa),
        .o_pressure_hpa       (o_pressure_hpa),
        .o_warm_alarm         (o_warm_alarm),
        .o_status             (o_status)
    );
endmodule

/* hdl/bsc_div.sv */
// pipelined unsigned 32-bit restoring divider, one quotient bit per stage
module bsc_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic [31:0] o_quotient
);
    import bsc_pkg::*;

    logic [31:0] r_rem [DIV_STAGES];
    logic [31:0] r_dq  [DIV_STAGES];
    logic [31:0] r_den [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            logic [31:0] w_rem_in, w_dq_in, w_den_in;
            logic [32:0] w_trial;
            logic        w_fit;
            if (s == 0) begin : g_first
                assign w_rem_in = 32'd0;
                assign w_dq_in  = i_dividend;
                assign w_den_in = i_divisor;
            end else begin : g_next
                assign w_rem_in = r_rem[s-1];
                assign w_dq_in  = r_dq[s-1];
                assign w_den_in = r_den[s-1];
            end
            assign w_trial = {w_rem_in, w_dq_in[31]};
            assign w_fit   = w_trial >= {1'b0, w_den_in};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_fit ? 32'(w_trial - {1'b0, w_den_in}) : w_trial[31:0];
                    r_dq[s]  <= {w_dq_in[30:0], w_fit};
                    r_den[s] <= w_den_in;
                end
            end
        end
    endgenerate

    assign o_quotient = r_dq[DIV_STAGES-1];
endmodule

/* hdl/bsc_queue.sv */
// small item queue between front and back end
module bsc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output bsc_pkg::t_item o_item
);
    import bsc_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0] r_wp, r_rp;

    assign o_empty = r_wp == r_rp;
    assign o_full  = (r_wp[QUEUE_AW] != r_rp[QUEUE_AW])
                  && (r_wp[QUEUE_AW-1:0] == r_rp[QUEUE_AW-1:0]);
    assign o_item  = r_mem[r_rp[QUEUE_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[QUEUE_AW-1:0]] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
        end
    end
endmodule

/* hdl/bsc_front.sv */
// front end: takes raw samples, forms the first temperature term and flags a zero divisor
module bsc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsc_pkg::t_cal  i_cal,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [15:0]    i_raw_temperature,
    input  logic [15:0]    i_raw_pressure,
    output logic           o_push,
    output bsc_pkg::t_item o_item,
    input  logic           i_full
);
    import bsc_pkg::*;

    logic        r_v1, r_v2;
    logic [31:0] r_prod;
    logic [15:0] r_up1;
    t_item       r_item;
    logic        w_en;
    logic [31:0] w_diff, w_x1, w_d;

    assign w_en    = !r_v2 || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_v2 && !i_full;
    assign o_item  = r_item;

    assign w_diff = {16'd0, i_raw_temperature} - {16'd0, i_cal.ac6};
    assign w_x1   = sdiv_p2(r_prod, 15);
    assign w_d    = w_x1 + sx16(i_cal.mc_md[15:0]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= 32'(w_diff * {16'd0, i_cal.ac5});
            r_up1  <= i_raw_pressure;
            r_item.up       <= r_up1;
            r_item.x1       <= w_x1;
            r_item.d        <= w_d;
            r_item.zero_div <= w_d == 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end
endmodule

/* hdl/bsc_back.sv */
// back end: remaining compensation pipeline with two dividers and output register
module bsc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsc_pkg::t_cal  i_cal,
    input  logic           i_empty,
    input  bsc_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [12:0]    o_temperature_tenths,
    output logic [17:0]    o_pressure_pa,
    output logic [11:0]    o_pressure_hpa,
    output logic           o_warm_alarm,
    output logic [1:0]     o_status
);
    import bsc_pkg::*;

    localparam int LAT = 2 * DIV_STAGES + 16;

    typedef struct packed {
        logic [15:0] up;
        logic [31:0] x1;
        logic        neg;
        logic        zero;
    } t_side1;

    typedef struct packed {
        logic [31:0] t;
        logic        zero;
        logic        b7_pos;
    } t_side2;

    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en  = !r_vld[LAT-1] || i_ready;
    assign o_pop = w_en && !i_empty;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], !i_empty};
        end
    end

    // s0: magnitudes for mc*2048 / d
    logic [31:0] w_num1;
    logic [31:0] r0_ma, r0_mb;
    t_side1      r0_side;
    assign w_num1 = sx16(i_cal.mc_md[31:16]) << 11;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_ma        <= w_num1[31] ? 32'd0 - w_num1 : w_num1;
            r0_mb        <= i_item.d[31] ? 32'd0 - i_item.d : i_item.d;
            r0_side.up   <= i_item.up;
            r0_side.x1   <= i_item.x1;
            r0_side.neg  <= w_num1[31] ^ i_item.d[31];
            r0_side.zero <= i_item.zero_div;
        end
    end

    logic [31:0] w_q1;
    t_side1      r_sd1 [DIV_STAGES];
    bsc_div u_div1 (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r0_ma),
        .i_divisor  (r0_mb),
        .o_quotient (w_q1)
    );
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd1[0] <= r0_side;
            for (int i = 1; i < DIV_STAGES; i++) r_sd1[i] <= r_sd1[i-1];
        end
    end

    // s1..s8: b5, t, b6 and the pressure coefficients
    t_side1      w_s1;
    logic [31:0] w_x2, w_b5;
    logic [31:0] r1_t, r1_b6;
    logic [15:0] r1_up;
    logic        r1_zero;
    assign w_s1 = r_sd1[DIV_STAGES-1];
    assign w_x2 = w_s1.neg ? 32'd0 - w_q1 : w_q1;
    assign w_b5 = w_s1.x1 + w_x2;

    logic [31:0] r2_b6b6, r2_ac2b6, r2_ac3b6, r2_t;
    logic [15:0] r2_up;
    logic        r2_zero;
    logic [31:0] r3_sq, r3_x2a, r3_x1c, r3_t;
    logic [15:0] r3_up;
    logic        r3_zero;
    logic [31:0] r4_b2sq, r4_b1sq, r4_x2a, r4_x1c, r4_t;
    logic [15:0] r4_up;
    logic        r4_zero;
    logic [31:0] r5_x3, r5_x3b, r5_t;
    logic [15:0] r5_up;
    logic        r5_zero;
    logic [31:0] r6_b3, r6_x3b, r6_t;
    logic [15:0] r6_up;
    logic        r6_zero;
    logic [31:0] r7_b4p, r7_b7, r7_t;
    logic        r7_zero;
    logic [31:0] r8_num, r8_den;
    t_side2      r8_side;
    logic [31:0] w_x1_5, w_x2_5, w_b4;

    assign w_x1_5 = sdiv_p2(r4_b2sq, 11);
    assign w_x2_5 = sdiv_p2(r4_b1sq, 16);
    assign w_b4   = r7_b4p >> 15;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_t    <= sdiv_p2(w_b5 + K_B5_ROUND, 4);
            r1_b6   <= w_b5 - K_B6_OFF;
            r1_up   <= w_s1.up;
            r1_zero <= w_s1.zero;

            r2_b6b6  <= 32'(r1_b6 * r1_b6);
            r2_ac2b6 <= 32'(sx16(i_cal.ac2) * r1_b6);
            r2_ac3b6 <= 32'(sx16(i_cal.ac3) * r1_b6);
            r2_t     <= r1_t;
            r2_up    <= r1_up;
            r2_zero  <= r1_zero;

            r3_sq   <= sdiv_p2(r2_b6b6, 12);
            r3_x2a  <= sdiv_p2(r2_ac2b6, 11);
            r3_x1c  <= sdiv_p2(r2_ac3b6, 13);
            r3_t    <= r2_t;
            r3_up   <= r2_up;
            r3_zero <= r2_zero;

            r4_b2sq <= 32'(sx16(i_cal.b1_b2[15:0]) * r3_sq);
            r4_b1sq <= 32'(sx16(i_cal.b1_b2[31:16]) * r3_sq);
            r4_x2a  <= r3_x2a;
            r4_x1c  <= r3_x1c;
            r4_t    <= r3_t;
            r4_up   <= r3_up;
            r4_zero <= r3_zero;

            r5_x3   <= w_x1_5 + r4_x2a;
            r5_x3b  <= r4_x1c + w_x2_5 + K_TWO;
            r5_t    <= r4_t;
            r5_up   <= r4_up;
            r5_zero <= r4_zero;

            r6_b3   <= sdiv_p2((sx16(i_cal.ac1) << 2) + r5_x3 + K_TWO, 2);
            r6_x3b  <= sdiv_p2(r5_x3b, 2);
            r6_t    <= r5_t;
            r6_up   <= r5_up;
            r6_zero <= r5_zero;

            r7_b4p  <= 32'({16'd0, i_cal.ac4} * (r6_x3b + K_AC4_OFF));
            r7_b7   <= 32'(({16'd0, r6_up} - r6_b3) * K_B7_MUL);
            r7_t    <= r6_t;
            r7_zero <= r6_zero;

            r8_num         <= r7_b7[31] ? r7_b7 : r7_b7 << 1;
            r8_den         <= w_b4;
            r8_side.t      <= r7_t;
            r8_side.zero   <= r7_zero || (w_b4 == 32'd0);
            r8_side.b7_pos <= !r7_b7[31];
        end
    end

    logic [31:0] w_q2;
    t_side2      r_sd2 [DIV_STAGES];
    bsc_div u_div2 (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r8_num),
        .i_divisor  (r8_den),
        .o_quotient (w_q2)
    );
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd2[0] <= r8_side;
            for (int i = 1; i < DIV_STAGES; i++) r_sd2[i] <= r_sd2[i-1];
        end
    end

    // s9..s15: pressure correction, clamping, hPa conversion and output register
    t_side2      w_s9;
    logic [31:0] r9_p, r9_x1, r9_t;
    logic        r9_zero;
    logic [31:0] r10_x1sq, r10_x2m, r10_p, r10_t;
    logic        r10_zero;
    logic [31:0] r11_x1m, r11_x2, r11_p, r11_t;
    logic        r11_zero;
    logic [31:0] r12_p, r12_t;
    logic        r12_zero;
    logic [12:0] r13_temp;
    logic [17:0] r13_pa;
    logic        r13_warm;
    logic [1:0]  r13_status;
    logic [36:0] r14_hprod;
    logic [12:0] r14_temp;
    logic [17:0] r14_pa;
    logic        r14_warm;
    logic [1:0]  r14_status;
    logic [12:0] r15_temp;
    logic [17:0] r15_pa;
    logic [11:0] r15_hpa;
    logic        r15_warm;
    logic [1:0]  r15_status;

    logic [31:0] w_p9, w_x1_12;
    logic signed [31:0] w_ts, w_ps;
    logic        w_tsat, w_psat;
    logic [12:0] w_tc;
    logic [17:0] w_pc;

    assign w_s9    = r_sd2[DIV_STAGES-1];
    assign w_p9    = w_s9.b7_pos ? w_q2 : w_q2 << 1;
    assign w_x1_12 = sdiv_p2(r11_x1m, 16);
    assign w_ts    = $signed(r12_t);
    assign w_ps    = $signed(r12_p);

    always_comb begin
        w_tsat = 1'b1;
        w_psat = 1'b1;
        if (w_ts > T_MAX)      w_tc = T_MAX[12:0];
        else if (w_ts < T_MIN) w_tc = T_MIN[12:0];
        else begin
            w_tc   = w_ts[12:0];
            w_tsat = 1'b0;
        end
        if (w_ps > P_MAX)           w_pc = P_MAX[17:0];
        else if (w_ps < 32'sd0)     w_pc = 18'd0;
        else begin
            w_pc   = w_ps[17:0];
            w_psat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_p    <= w_p9;
            r9_x1   <= sdiv_p2(w_p9, 8);
            r9_t    <= w_s9.t;
            r9_zero <= w_s9.zero;

            r10_x1sq <= 32'(r9_x1 * r9_x1);
            r10_x2m  <= 32'(K_P_MUL2 * r9_p);
            r10_p    <= r9_p;
            r10_t    <= r9_t;
            r10_zero <= r9_zero;

            r11_x1m  <= 32'(r10_x1sq * K_P_MUL1);
            r11_x2   <= sdiv_p2(r10_x2m, 16);
            r11_p    <= r10_p;
            r11_t    <= r10_t;
            r11_zero <= r10_zero;

            r12_p    <= r11_p + sdiv_p2(w_x1_12 + r11_x2 + K_P_OFF, 4);
            r12_t    <= r11_t;
            r12_zero <= r11_zero;

            if (r12_zero) begin
                r13_temp   <= '0;
                r13_pa     <= '0;
                r13_warm   <= 1'b0;
                r13_status <= ST_ZERO_DIV;
            end else begin
                r13_temp   <= w_tc;
                r13_pa     <= w_pc;
                r13_warm   <= w_ts > T_WARM;
                r13_status <= (w_tsat || w_psat) ? ST_SAT : ST_OK;
            end

            r14_hprod  <= {19'd0, r13_pa} * {18'd0, HPA_RECIP};
            r14_temp   <= r13_temp;
            r14_pa     <= r13_pa;
            r14_warm   <= r13_warm;
            r14_status <= r13_status;

            r15_hpa    <= r14_hprod[HPA_SHIFT +: 12];
            r15_temp   <= r14_temp;
            r15_pa     <= r14_pa;
            r15_warm   <= r14_warm;
            r15_status <= r14_status;
        end
    end

    assign o_temperature_tenths = r15_temp;
    assign o_pressure_pa        = r15_pa;
    assign o_pressure_hpa       = r15_hpa;
    assign o_warm_alarm         = r15_warm;
    assign o_status             = r15_status;
endmodule
